@@ hw/rtl/gn3d_pkg.sv @@
// gn3d_pkg: shared constants, permutation table and rounding helper for the
// 3d gradient noise unit. no dependencies.
package gn3d_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned NOISE_W       = 20;
  localparam int unsigned CELL_W        = 8;
  localparam int unsigned CODE_W        = 4;
  localparam int unsigned CORNERS       = 8;

  // gradient codes that take x as the second term
  localparam logic [CODE_W-1:0] GRAD_CODE_YX_A = 4'd12;
  localparam logic [CODE_W-1:0] GRAD_CODE_YX_B = 4'd14;

  localparam logic [CELL_W-1:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
    8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
    8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
    8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
    8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
    8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
    8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
    8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
    8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
    8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
    8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
    8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
    8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
    8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
    8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
    8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
    8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
    8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  function automatic logic [CELL_W-1:0] perm(logic [CELL_W-1:0] idx);
    return PERM[idx];
  endfunction

  // add half an lsb, then floor shift
  function automatic logic signed [63:0] rnd(logic signed [63:0] p, int unsigned f);
    logic signed [63:0] half;
    half = 64'sd1 <<< (f - 1);
    return (p + half) >>> f;
  endfunction

endpackage

@@ hw/rtl/gn3d_fade.sv @@
// gn3d_fade: three stage quintic fade curve for one axis.
// depends on gn3d_pkg.
module gn3d_fade import gn3d_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [FRAC_BITS-1:0]   t_i,
  output logic [FRAC_BITS+5:0]   fade_o
);
  localparam int unsigned W   = FRAC_BITS + 6;
  localparam int          ONE = 1 << FRAC_BITS;

  logic signed [W-1:0] tw, k;
  logic signed [2*W-1:0] p_tt, p_ti, p_t3, p_f;
  logic signed [W-1:0] t1_q, tt_q, ti_q, t3_q, inner_q, fade_q;

  always_comb begin
    tw   = signed'(W'(t_i));
    k    = (tw <<< 2) + (tw <<< 1) - signed'(W'(15 * ONE));
    p_tt = tw * tw;
    p_ti = tw * k;
    p_t3 = tt_q * t1_q;
    p_f  = t3_q * inner_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q    <= tw;
      tt_q    <= W'(rnd(64'(p_tt), FRAC_BITS));
      ti_q    <= W'(rnd(64'(p_ti), FRAC_BITS));
      t3_q    <= W'(rnd(64'(p_t3), FRAC_BITS));
      inner_q <= ti_q + signed'(W'(10 * ONE));
      fade_q  <= W'(rnd(64'(p_f), FRAC_BITS));
    end
  end

  assign fade_o = fade_q;

endmodule

@@ hw/rtl/gn3d_hash.sv @@
// gn3d_hash: three stage corner hash through the permutation table.
// depends on gn3d_pkg.
module gn3d_hash import gn3d_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [CELL_W-1:0] cx_i,
  input  logic [CELL_W-1:0] cy_i,
  input  logic [CELL_W-1:0] cz_i,
  output logic [CODE_W-1:0] codes_o [CORNERS]
);
  logic [CELL_W-1:0] a_q, b_q, cz1_q;
  logic [CELL_W-1:0] aa_q, ab_q, ba_q, bb_q;
  logic [CODE_W-1:0] codes_q [CORNERS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= perm(cx_i) + cy_i;
      b_q   <= perm(cx_i + 8'd1) + cy_i;
      cz1_q <= cz_i;
      aa_q  <= perm(a_q) + cz1_q;
      ab_q  <= perm(a_q + 8'd1) + cz1_q;
      ba_q  <= perm(b_q) + cz1_q;
      bb_q  <= perm(b_q + 8'd1) + cz1_q;
      // corner order: bit0 x+1, bit1 y+1, bit2 z+1
      codes_q[0] <= CODE_W'(perm(aa_q));
      codes_q[1] <= CODE_W'(perm(ba_q));
      codes_q[2] <= CODE_W'(perm(ab_q));
      codes_q[3] <= CODE_W'(perm(bb_q));
      codes_q[4] <= CODE_W'(perm(aa_q + 8'd1));
      codes_q[5] <= CODE_W'(perm(ba_q + 8'd1));
      codes_q[6] <= CODE_W'(perm(ab_q + 8'd1));
      codes_q[7] <= CODE_W'(perm(bb_q + 8'd1));
    end
  end

  assign codes_o = codes_q;

endmodule

@@ hw/rtl/gradient_noise_3d_unit.sv @@
// gradient_noise_3d_unit: pipelined 3d gradient noise, one point per cycle.
// path: fade and hash stages, gradient, x, y and z lerps, output register.
// throughput: one transaction per cycle; the whole pipeline holds while the
// output register is full and not taken.
// reset: rst_ni clears all valid bits; payload registers are not reset.
// depends on gn3d_pkg, gn3d_fade, gn3d_hash.
module gradient_noise_3d_unit import gn3d_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_z_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [NOISE_W-1:0] noise_value_o
);
  localparam int unsigned W     = FRAC_BITS + 6;
  localparam int unsigned RW    = W + 8;
  localparam int          ONE   = 1 << FRAC_BITS;
  localparam int          SHIFT = FRAC_BITS - 16;
  localparam int unsigned STAGES = 7;

  logic en;
  logic [STAGES-1:0] vld_q;
  logic out_vld_q;

  assign en          = !out_vld_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[STAGES-2:0], in_valid_i};
      out_vld_q <= vld_q[STAGES-1];
    end
  end

  // cell fraction to FRAC_BITS bits
  function automatic logic [FRAC_BITS-1:0] to_frac(logic [COORD_W-1:0] raw);
    logic [39:0] ext;
    ext = {raw[15:0], 24'd0};
    return FRAC_BITS'(ext >> (40 - FRAC_BITS));
  endfunction

  function automatic logic signed [W-1:0] grad(logic [CODE_W-1:0] h,
      logic signed [W-1:0] x, logic signed [W-1:0] y, logic signed [W-1:0] z);
    logic signed [W-1:0] u, v;
    u = h[3] ? y : x;
    if (h[3:2] == 2'b00)                              v = y;
    else if (h == GRAD_CODE_YX_A || h == GRAD_CODE_YX_B) v = x;
    else                                              v = z;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  logic [FRAC_BITS-1:0] fx, fy, fz;
  assign fx = to_frac(coord_x_i);
  assign fy = to_frac(coord_y_i);
  assign fz = to_frac(coord_z_i);

  logic [W-1:0] u_w, v_w, w_w;
  logic [CODE_W-1:0] codes [CORNERS];

  gn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (.clk_i, .en_i(en), .t_i(fx), .fade_o(u_w));
  gn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (.clk_i, .en_i(en), .t_i(fy), .fade_o(v_w));
  gn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (.clk_i, .en_i(en), .t_i(fz), .fade_o(w_w));

  gn3d_hash u_hash (
    .clk_i,
    .en_i   (en),
    .cx_i   (coord_x_i[23:16]),
    .cy_i   (coord_y_i[23:16]),
    .cz_i   (coord_z_i[23:16]),
    .codes_o(codes)
  );

  // fraction delay line to line up with the codes
  logic [FRAC_BITS-1:0] fx_q [3], fy_q [3], fz_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_q[0] <= fx;      fy_q[0] <= fy;      fz_q[0] <= fz;
      fx_q[1] <= fx_q[0]; fy_q[1] <= fy_q[0]; fz_q[1] <= fz_q[0];
      fx_q[2] <= fx_q[1]; fy_q[2] <= fy_q[1]; fz_q[2] <= fz_q[1];
    end
  end

  logic signed [W-1:0] x0, y0, z0, x1, y1, z1;
  logic signed [W-1:0] g_d [CORNERS];
  always_comb begin
    x0 = signed'(W'(fx_q[2]));
    y0 = signed'(W'(fy_q[2]));
    z0 = signed'(W'(fz_q[2]));
    x1 = x0 - signed'(W'(ONE));
    y1 = y0 - signed'(W'(ONE));
    z1 = z0 - signed'(W'(ONE));
    for (int i = 0; i < CORNERS; i++) begin
      g_d[i] = grad(codes[i], (i % 2 == 1) ? x1 : x0, ((i / 2) % 2 == 1) ? y1 : y0,
                    (i / 4 == 1) ? z1 : z0);
    end
  end

  // gradient stage
  logic signed [W-1:0] g_q [CORNERS];
  logic signed [W-1:0] u4_q, v4_q, w4_q;
  // lerp along x
  logic signed [2*W-1:0] px_q [4];
  logic signed [W-1:0] ax_q [4];
  logic signed [W-1:0] v5_q, w5_q;
  // lerp along y
  logic signed [W-1:0] lx [4];
  logic signed [2*W-1:0] py_q [2];
  logic signed [W-1:0] ay_q [2];
  logic signed [W-1:0] w6_q;
  // lerp along z
  logic signed [W-1:0] ly [2];
  logic signed [2*W-1:0] pz_q;
  logic signed [W-1:0] az_q;
  logic signed [W-1:0] r;
  logic signed [RW-1:0] rs;
  logic signed [NOISE_W-1:0] noise_d, noise_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lx[i] = ax_q[i] + W'(rnd(64'(px_q[i]), FRAC_BITS));
    end
    for (int i = 0; i < 2; i++) begin
      ly[i] = ay_q[i] + W'(rnd(64'(py_q[i]), FRAC_BITS));
    end
    r = az_q + W'(rnd(64'(pz_q), FRAC_BITS));
  end

  generate
    if (SHIFT > 0) begin : g_rshift
      assign rs = RW'(rnd(64'(r), SHIFT));
    end else if (SHIFT == 0) begin : g_noshift
      assign rs = RW'(r);
    end else begin : g_lshift
      assign rs = RW'(r) <<< (-SHIFT);
    end
  endgenerate

  always_comb begin
    if (rs > RW'(524287))       noise_d = NOISE_W'(524287);
    else if (rs < -RW'(524288)) noise_d = NOISE_W'(-524288);
    else                        noise_d = NOISE_W'(rs);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_q  <= g_d;
      u4_q <= u_w; v4_q <= v_w; w4_q <= w_w;
      for (int i = 0; i < 4; i++) begin
        px_q[i] <= u4_q * (g_q[2*i+1] - g_q[2*i]);
        ax_q[i] <= g_q[2*i];
      end
      v5_q <= v4_q; w5_q <= w4_q;
      for (int i = 0; i < 2; i++) begin
        py_q[i] <= v5_q * (lx[2*i+1] - lx[2*i]);
        ay_q[i] <= lx[2*i];
      end
      w6_q <= w5_q;
      pz_q <= w6_q * (ly[1] - ly[0]);
      az_q <= ly[0];
      noise_q <= noise_d;
    end
  end

  assign noise_value_o = noise_q;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && out_vld_q)
    else $error("pipeline moved during a stall");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_ready_o)
    else $error("input blocked while output register empty");

  a_last_stage_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[STAGES-1] |=> out_vld_q)
    else $error("last stage transaction lost");

endmodule
